// File: rtl/spq_pkg.sv
package spq_pkg;

  // Default queue depth
  localparam int CAPACITY_DEFAULT = 16;

  localparam int PRIO_W     = 8;
  localparam int CONTENTS_W = 16;

  // Request codes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2
  } req_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0]     prio;
    logic [CONTENTS_W-1:0] contents;
  } entry_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic                  insert;
    logic                  remove;
    logic [PRIO_W-1:0]     prio;
    logic [CONTENTS_W-1:0] contents;
  } cell_ctrl_t;

endpackage

// File: rtl/stable_priority_queue.sv
// Stable priority queue built as a sorted chain of cells.
// Each request's result is loaded into the output register at its transfer.
// Throughput: one request per cycle while no held result blocks s_tready; every
// cell compares with the new priority in parallel and shifts by one place in the same cycle.
// Reset: synchronous; clears the fill count and the result valid flag,
// cell contents are left as they are and are never read before written.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_priority[7:0], in_contents[23:8]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_contents[15:0], out_priority[23:16],
                                 // is_empty[24], is_full[25], error_code[27:26],
                                 // zero[31:28]
  output logic        m_tuser    // item_valid
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  req_t             req;
  cell_ctrl_t       ctrl;

  entry_t           cell_data  [CAPACITY];
  entry_t           left_data  [CAPACITY];
  entry_t           right_data [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] left_gt;

  logic             res_item_valid;
  entry_t           res_entry;
  err_t             res_err;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign req      = req_t'(s_tuser);
  assign full     = count == CNT_W'(CAPACITY);
  assign empty    = count == '0;

  // Decode the request into chain control
  always_comb begin
    ctrl.insert   = accept && (req == REQ_INSERT) && !full;
    ctrl.remove   = accept && (req == REQ_REMOVE) && !empty;
    ctrl.prio     = s_tdata[7:0];
    ctrl.contents = s_tdata[23:8];
  end

  // Advance the fill count
  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Chain of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_data[i] = '0;
      assign left_gt[i]   = 1'b0;
    end else begin : g_mid
      assign left_data[i] = cell_data[i-1];
      assign left_gt[i]   = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_data[i] = cell_data[i];
    end else begin : g_body
      assign right_data[i] = cell_data[i+1];
    end

    spq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .left_data  (left_data[i]),
      .left_gt    (left_gt[i]),
      .right_data (right_data[i]),
      .data       (cell_data[i]),
      .gt         (cell_gt[i])
    );
  end

  // Form the result of the request
  always_comb begin
    res_item_valid = 1'b0;
    res_entry      = '0;
    res_err        = ERR_OK;
    case (req)
      REQ_INSERT: begin
        if (full) begin
          res_err = ERR_FULL;
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        if (empty) begin
          res_err = ERR_EMPTY;
        end else begin
          res_item_valid = 1'b1;
          res_entry      = cell_data[0];
        end
      end
      default: begin
        res_err = ERR_OK;
      end
    endcase
  end

  // Output register: load on transfer in, drop on transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser        <= res_item_valid;
      m_tdata[15:0]  <= res_entry.contents;
      m_tdata[23:16] <= res_entry.prio;
      m_tdata[24]    <= count_next == '0;
      m_tdata[25]    <= count_next == CNT_W'(CAPACITY);
      m_tdata[27:26] <= res_err;
      m_tdata[31:28] <= '0;
    end
  end

  // Fill count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // Insert into a non-full queue grows it by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the queue");

  // A full error is only reported with the full flag set
  a_full_err: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[27:26] == ERR_FULL)) |-> m_tdata[25])
    else $error("full error without full flag");

  // A returned item never comes with an error
  a_item_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[27:26] == ERR_OK))
    else $error("item returned with error");

endmodule

// File: rtl/spq_cell.sv
module spq_cell
  import spq_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] count,
  input  entry_t           left_data,
  input  logic             left_gt,
  input  entry_t           right_data,
  output entry_t           data,
  output logic             gt
);

  logic valid;

  // Cell holds a live entry when it lies below the fill count
  assign valid = count > CNT_W'(INDEX);

  // Live entry that must move behind the incoming one
  assign gt = valid && (data.prio > ctrl.prio);

  // Shift right on insert, left on remove, otherwise hold
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_gt) begin
        data <= left_data;
      end else if (gt || !valid) begin
        data.prio     <= ctrl.prio;
        data.contents <= ctrl.contents;
      end
    end else if (ctrl.remove) begin
      data <= right_data;
    end
  end

endmodule

// File: verif/spq_checker.sv
// Watches both stream channels of the priority queue, keeps its own sorted
// copy of the entries, and compares every result transfer with the reply
// predicted for the oldest outstanding request.
module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // in_priority[7:0], in_contents[23:8]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // out_contents[15:0], out_priority[23:16],
                                 // is_empty[24], is_full[25], error_code[27:26]
  input  logic        m_tuser,   // item_valid
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic                  item_valid;
    logic [CONTENTS_W-1:0] contents;
    logic [PRIO_W-1:0]     prio;
    logic                  empty;
    logic                  full;
    err_t                  err;
  } reply_t;

  localparam int REPORT_LIMIT = 10;

  // Sorted copy of the queue, index 0 is the head
  entry_t held_entry [CAPACITY];
  int     held_count;
  reply_t replies_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    held_count = 0;
  end

  // Apply one request to the held entries and return the reply it causes
  function automatic reply_t serve_request(input logic [1:0] code,
                                           input logic [PRIO_W-1:0] prio,
                                           input logic [CONTENTS_W-1:0] contents);
    reply_t r;
    int     pos;
    r = '0;
    r.err = ERR_OK;
    case (code)
      REQ_INSERT: begin
        if (held_count >= CAPACITY) begin
          r.err = ERR_FULL;
        end else begin
          // land after every entry of equal priority to keep arrival order
          pos = 0;
          while (pos < held_count && held_entry[pos].prio <= prio) pos++;
          for (int i = held_count; i > pos; i--) held_entry[i] = held_entry[i-1];
          held_entry[pos].prio     = prio;
          held_entry[pos].contents = contents;
          held_count++;
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        if (held_count == 0) begin
          r.err = ERR_EMPTY;
        end else begin
          r.item_valid = 1'b1;
          r.contents   = held_entry[0].contents;
          r.prio       = held_entry[0].prio;
          if (code == REQ_REMOVE) begin
            for (int i = 1; i < held_count; i++) held_entry[i-1] = held_entry[i];
            held_count--;
          end
        end
      end
      default: ;  // unused code leaves the queue alone
    endcase
    r.empty = (held_count == 0);
    r.full  = (held_count >= CAPACITY);
    return r;
  endfunction

  // Check result transfers first: a result never belongs to a request
  // accepted at the same edge, since the block registers its output
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      held_count = 0;
      replies_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.item_valid = m_tuser;
        got.contents   = m_tdata[15:0];
        got.prio       = m_tdata[23:16];
        got.empty      = m_tdata[24];
        got.full       = m_tdata[25];
        got.err        = err_t'(m_tdata[27:26]);
        if (replies_due.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("unexpected result: v=%b c=%h p=%h e=%b f=%b err=%0d",
                     got.item_valid, got.contents, got.prio, got.empty, got.full, got.err);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (got !== want || m_tdata[31:28] !== 4'd0) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("mismatch expected: v=%b c=%h p=%h e=%b f=%b err=%0d",
                       want.item_valid, want.contents, want.prio, want.empty, want.full,
                       want.err);
              $display("         actual:   v=%b c=%h p=%h e=%b f=%b err=%0d pad=%h",
                       got.item_valid, got.contents, got.prio, got.empty, got.full,
                       got.err, m_tdata[31:28]);
            end
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        replies_due.push_back(serve_request(s_tuser, s_tdata[7:0], s_tdata[23:8]));
    end
    pending = replies_due.size();
  end

endmodule

// File: verif/tb.sv
// Drives requests into the priority queue and a random backpressure on its
// result channel; the checker beside the block predicts and compares.
module tb;
  import spq_pkg::*;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam int         IDLE_PCT       = 34;
  localparam int         RANDOM_ITEMS   = 400;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  logic steady = 1'b0;  // suppress idling on both sides
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stable_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  spq_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Random backpressure on the result side
  always @(negedge clk) begin
    m_tready = steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Present one request after a random gap and hold it until its transfer
  task automatic send_request(input logic [1:0] code, input logic [7:0] prio,
                              input logic [15:0] contents);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = code;
    s_tdata  = {contents, prio};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int          mode;
    int          pick;
    logic [1:0]  code;
    logic [7:0]  prio;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty errors, extremes, ties, ignored code, drain past empty
    send_request(REQ_REMOVE, 8'h00, 16'h0000);
    send_request(REQ_PEEK,   8'h00, 16'h0000);
    send_request(REQ_UNUSED, 8'hff, 16'hffff);
    send_request(REQ_INSERT, 8'hff, 16'hffff);
    send_request(REQ_INSERT, 8'h00, 16'h0000);
    send_request(REQ_INSERT, 8'h00, 16'hffff);
    send_request(REQ_INSERT, 8'h80, 16'h5a5a);
    send_request(REQ_INSERT, 8'h80, 16'ha5a5);
    send_request(REQ_INSERT, 8'h80, 16'h0001);
    send_request(REQ_PEEK,   8'h00, 16'h0000);
    send_request(REQ_UNUSED, 8'h00, 16'h0000);
    repeat (6) send_request(REQ_REMOVE, 8'h00, 16'h0000);
    send_request(REQ_REMOVE, 8'hff, 16'hffff);
    send_request(REQ_PEEK,   8'hff, 16'hffff);

    // Random: rotate through fill, drain and mixed phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 160 && n < 240);
      mode = (n / 40) % 3;
      pick = $urandom_range(99);
      if (pick < 3)
        code = REQ_UNUSED;
      else if (pick < (mode == 0 ? 78 : mode == 1 ? 28 : 50))
        code = REQ_INSERT;
      else if (pick < (mode == 0 ? 90 : mode == 1 ? 85 : 80))
        code = REQ_REMOVE;
      else
        code = REQ_PEEK;
      // narrow priorities half the time to force ties
      prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      send_request(code, prio, 16'($urandom_range(65535)));
    end
    steady   = 1'b0;
    s_tvalid = 1'b0;

    // Drain outstanding results, then wait a little longer for strays
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
